FILE: hw/rtl/mtdq_pkg.sv
// shared types, codes and constants of the timer deadline queue
package mtdq_pkg;

	// widths fixed by the command and response words
	localparam int ID_W = 4;
	localparam int TIMEOUT_W = 32;
	localparam int TICK_W = 64;
	localparam int CNT_W = 32;

	// most expiries reported for one tick
	localparam int MAX_RESULTS = 16;

	// operation codes
	localparam logic [1:0] OP_SET = 2'd0;
	localparam logic [1:0] OP_CANCEL = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	// status codes
	localparam logic ST_OK = 1'b0;
	localparam logic ST_INVALID = 1'b1;

	// command word
	typedef struct packed {
		logic [1:0]           op;
		logic [ID_W-1:0]      timer_id;
		logic [TIMEOUT_W-1:0] timeout_ticks;
	} cmd_t;

	// response word
	typedef struct packed {
		logic             status;
		logic             expired_valid;
		logic [ID_W-1:0]  expired_id;
		logic [CNT_W-1:0] expiry_count;
		logic             last;
	} rsp_t;

	// build a response word
	function automatic rsp_t mk_rsp(logic st, logic ev, logic [ID_W-1:0] id,
		logic [CNT_W-1:0] cnt, logic lst);
		rsp_t r;
		r.status = st;
		r.expired_valid = ev;
		r.expired_id = id;
		r.expiry_count = cnt;
		r.last = lst;
		return r;
	endfunction

endpackage

FILE: hw/rtl/multi_timer_deadline_queue.sv
// top level of the sorted one-shot timer queue
// A bank of N_TIMERS one-shot timers held in one deadline-ordered queue in a small memory
// with one read and one write port; a word is taken when start is high and busy is low, and
// each response word sits on rsp for one cycle with done high and cannot be held off. A set
// walks down from the tail, shifting up each queued timer with a later deadline; a cancel
// walks the whole queue from the head, closing the gap behind the removed timer. A tick checks
// the head, and each expiry bumps its counter and then walks the queue to close the gap at
// its head. The walks move one queue entry per cycle through the memory's read and write
// ports. Up to 16 expiries are reported per tick, the last response of a command carrying
// last. No clearing pass follows reset.
module multi_timer_deadline_queue #(
	parameter int N_TIMERS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  mtdq_pkg::cmd_t  cmd,
	output logic            done,
	output mtdq_pkg::rsp_t  rsp
);

	localparam int IW = $clog2(N_TIMERS);
	localparam int CW = $clog2(N_TIMERS + 1);
	localparam int NW = $clog2(mtdq_pkg::MAX_RESULTS + 1);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_INS_RD = 4'd1;
	localparam logic [3:0] S_INS    = 4'd2;
	localparam logic [3:0] S_REM_RD = 4'd3;
	localparam logic [3:0] S_REM    = 4'd4;
	localparam logic [3:0] S_TRD    = 4'd5;
	localparam logic [3:0] S_TCHK   = 4'd6;
	localparam logic [3:0] S_TCNT   = 4'd7;

	typedef struct packed {
		logic [mtdq_pkg::TICK_W-1:0] dl;
		logic [IW-1:0]               id;
	} ent_t;

	logic [3:0]                  state_q;
	logic [mtdq_pkg::TICK_W-1:0] tick_q;
	logic [CW-1:0]               len_q;
	logic [N_TIMERS-1:0]         armed_q;
	logic [CW-1:0]               pos_q;
	logic                        found_q;
	logic [IW-1:0]               tgt_q;
	ent_t                        new_q;
	logic                        tmode_q;
	logic [NW-1:0]               n_q;
	logic                        pv_q;
	logic [IW-1:0]               pid_q;
	logic [mtdq_pkg::CNT_W-1:0]  pcnt_q;
	logic                        done_q;
	mtdq_pkg::rsp_t              rsp_q;

	ent_t                        q_mem [N_TIMERS];
	ent_t                        rd_q;

	logic [IW-1:0]               raddr;
	logic                        we;
	logic [IW-1:0]               waddr;
	ent_t                        wdata;
	logic [CW-1:0]               pos_dec;
	logic [CW-1:0]               pos_dec2;
	logic [CW-1:0]               pos_inc;
	logic [CW-1:0]               len_dec;
	logic [IW-1:0]               idx;
	logic                        id_ok;
	logic                        shift_up;
	logic                        due;
	logic [IW-1:0]               cnt_id;
	logic                        cnt_bump;
	logic [mtdq_pkg::CNT_W-1:0]  cnt_new;

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp = rsp_q;

	// address arithmetic for the walks
	assign pos_dec = pos_q - CW'(1);
	assign pos_dec2 = pos_q - CW'(2);
	assign pos_inc = pos_q + CW'(1);
	assign len_dec = len_q - CW'(1);

	// command decode
	assign idx = IW'(cmd.timer_id);
	assign id_ok = (32'(cmd.timer_id) < N_TIMERS);

	// insertion keeps shifting while the entry below has a later deadline
	assign shift_up = (pos_q != '0) && (rd_q.dl > new_q.dl);

	// head of queue is due for expiry
	assign due = (len_q != '0) && (n_q < NW'(mtdq_pkg::MAX_RESULTS)) && (rd_q.dl <= tick_q);

	// queue memory port control
	always_comb begin
		raddr = '0;
		we = 1'b0;
		waddr = '0;
		wdata = new_q;
		case (state_q)
			S_INS_RD: begin
				raddr = len_dec[IW-1:0];
			end
			S_INS: begin
				raddr = pos_dec2[IW-1:0];
				we = 1'b1;
				waddr = pos_q[IW-1:0];
				wdata = shift_up ? rd_q : new_q;
			end
			S_REM: begin
				raddr = pos_inc[IW-1:0];
				we = found_q;
				waddr = pos_dec[IW-1:0];
				wdata = rd_q;
			end
			default: begin
				raddr = '0;
			end
		endcase
	end

	// queue memory
	always_ff @(posedge clk) begin
		if (we) begin
			q_mem[waddr] <= wdata;
		end
		rd_q <= q_mem[raddr];
	end

	// expiry counter access
	assign cnt_id = (state_q == S_TCHK) ? rd_q.id : tgt_q;
	assign cnt_bump = (state_q == S_TCNT);

	mtdq_cnt #(
		.N_TIMERS(N_TIMERS)
	) u_cnt (
		.clk       (clk),
		.arst_n    (arst_n),
		.id        (cnt_id),
		.bump      (cnt_bump),
		.count_new (cnt_new)
	);

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				new_q <= '{dl: tick_q + mtdq_pkg::TICK_W'(cmd.timeout_ticks), id: idx};
				tgt_q <= idx;
			end
			S_TCHK: begin
				tgt_q <= rd_q.id;
			end
			S_TCNT: begin
				pid_q <= tgt_q;
				pcnt_q <= cnt_new;
			end
			default: begin
				tgt_q <= tgt_q;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tick_q <= '0;
			len_q <= '0;
			armed_q <= '0;
			pos_q <= '0;
			found_q <= 1'b0;
			tmode_q <= 1'b0;
			n_q <= '0;
			pv_q <= 1'b0;
			done_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						case (cmd.op)
							mtdq_pkg::OP_SET: begin
								if (id_ok && !armed_q[idx]) begin
									armed_q[idx] <= 1'b1;
									pos_q <= len_q;
									state_q <= S_INS_RD;
								end else begin
									done_q <= 1'b1;
									rsp_q <= mtdq_pkg::mk_rsp(mtdq_pkg::ST_INVALID, 1'b0,
										'0, '0, 1'b1);
								end
							end
							mtdq_pkg::OP_CANCEL: begin
								if (id_ok && armed_q[idx]) begin
									armed_q[idx] <= 1'b0;
									tmode_q <= 1'b0;
									state_q <= S_REM_RD;
								end else begin
									done_q <= 1'b1;
									rsp_q <= mtdq_pkg::mk_rsp(mtdq_pkg::ST_INVALID, 1'b0,
										'0, '0, 1'b1);
								end
							end
							mtdq_pkg::OP_TICK: begin
								tick_q <= tick_q + mtdq_pkg::TICK_W'(1);
								n_q <= '0;
								pv_q <= 1'b0;
								state_q <= S_TRD;
							end
							default: begin
								done_q <= 1'b1;
								rsp_q <= mtdq_pkg::mk_rsp(mtdq_pkg::ST_INVALID, 1'b0,
									'0, '0, 1'b1);
							end
						endcase
					end
				end
				S_INS_RD: begin
					state_q <= S_INS;
				end
				// walk down from the tail, opening a slot for the new timer
				S_INS: begin
					if (shift_up) begin
						pos_q <= pos_dec;
					end else begin
						len_q <= len_q + CW'(1);
						done_q <= 1'b1;
						rsp_q <= mtdq_pkg::mk_rsp(mtdq_pkg::ST_OK, 1'b0, '0, '0, 1'b1);
						state_q <= S_IDLE;
					end
				end
				S_REM_RD: begin
					pos_q <= '0;
					found_q <= 1'b0;
					state_q <= S_REM;
				end
				// walk up from the head, closing the gap behind the removed timer
				S_REM: begin
					if (rd_q.id == tgt_q) begin
						found_q <= 1'b1;
					end
					if (pos_q == len_dec) begin
						len_q <= len_dec;
						if (tmode_q) begin
							state_q <= S_TRD;
						end else begin
							done_q <= 1'b1;
							rsp_q <= mtdq_pkg::mk_rsp(mtdq_pkg::ST_OK, 1'b0, '0, '0, 1'b1);
							state_q <= S_IDLE;
						end
					end else begin
						pos_q <= pos_inc;
					end
				end
				S_TRD: begin
					state_q <= S_TCHK;
				end
				// expire the head or finish; the held word goes out once its last flag is known
				S_TCHK: begin
					if (due) begin
						if (pv_q) begin
							done_q <= 1'b1;
							rsp_q <= mtdq_pkg::mk_rsp(mtdq_pkg::ST_OK, 1'b1,
								mtdq_pkg::ID_W'(pid_q), pcnt_q, 1'b0);
						end
						n_q <= n_q + NW'(1);
						state_q <= S_TCNT;
					end else begin
						done_q <= 1'b1;
						if (pv_q) begin
							rsp_q <= mtdq_pkg::mk_rsp(mtdq_pkg::ST_OK, 1'b1,
								mtdq_pkg::ID_W'(pid_q), pcnt_q, 1'b1);
						end else begin
							rsp_q <= mtdq_pkg::mk_rsp(mtdq_pkg::ST_OK, 1'b0, '0, '0, 1'b1);
						end
						state_q <= S_IDLE;
					end
				end
				S_TCNT: begin
					armed_q[tgt_q] <= 1'b0;
					pv_q <= 1'b1;
					tmode_q <= 1'b1;
					state_q <= S_REM_RD;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: hw/rtl/mtdq_cnt.sv
// per-timer expiry counters with saturating bump
module mtdq_cnt #(
	parameter int N_TIMERS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [$clog2(N_TIMERS)-1:0]      id,
	input  logic                             bump,
	output logic [mtdq_pkg::CNT_W-1:0]       count_new
);

	logic [mtdq_pkg::CNT_W-1:0] cnt_mem [N_TIMERS];
	logic [mtdq_pkg::CNT_W-1:0] rd_q;
	logic [N_TIMERS-1:0]        vld_q;
	logic [mtdq_pkg::CNT_W-1:0] cur;

	// count as it stands; never written reads as zero
	always_comb begin
		cur = vld_q[id] ? rd_q : '0;
		count_new = (&cur) ? cur : cur + mtdq_pkg::CNT_W'(1);
	end

	// counter store, registered read
	always_ff @(posedge clk) begin
		if (bump) begin
			cnt_mem[id] <= count_new;
		end
		rd_q <= cnt_mem[id];
	end

	// written marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (bump) begin
			vld_q[id] <= 1'b1;
		end
	end

endmodule

FILE: hw/rtl/mtdq_chk.sv
// port-level checks on the timer deadline queue and their binding
module mtdq_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input mtdq_pkg::cmd_t cmd,
	input logic           done,
	input mtdq_pkg::rsp_t rsp
);

	// an unused op code answers invalid in the very next cycle
	a_bad_op: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (cmd.op == mtdq_pkg::OP_NONE)
		|=> done && (rsp.status == mtdq_pkg::ST_INVALID) && rsp.last)
		else $error("unused op not answered as invalid");

	// a word that reports no expiry is always the only one of its command
	a_plain_last: assert property (@(posedge clk) disable iff (!arst_n)
		done && !rsp.expired_valid |-> rsp.last)
		else $error("non-expiry word without last");

	// an expiry is ok and carries a non-zero count
	a_expiry_word: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.expired_valid
		|-> (rsp.status == mtdq_pkg::ST_OK) && (rsp.expiry_count != '0))
		else $error("malformed expiry word");

	// more words pending keeps the block busy
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done && !rsp.last |-> busy)
		else $error("idle while words of a tick remain");

endmodule

bind multi_timer_deadline_queue mtdq_chk u_mtdq_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.done   (done),
	.rsp    (rsp)
);

FILE: test/multi_timer_deadline_queue_check.sv
`timescale 1ns / 100ps
// response checker with its own deadline-ordered timer bank predictor
module multi_timer_deadline_queue_check #(
	parameter int N_TIMERS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            busy,
	input  mtdq_pkg::cmd_t  cmd,
	input  logic            done,
	input  mtdq_pkg::rsp_t  rsp,
	output int              errors,
	output int              pending,
	output int              words_seen,
	output int              expiries_seen
);
	import mtdq_pkg::*;

	// predicted state of the timer bank
	logic [TICK_W-1:0] now_tick;
	logic [TICK_W-1:0] due_at [N_TIMERS];
	logic              is_armed [N_TIMERS];
	logic [CNT_W-1:0]  fire_count [N_TIMERS];
	int unsigned       deadline_order [$];

	// response words still to come, oldest first
	rsp_t expected_rsp [$];
	rsp_t want;

	// one line per mismatch, counted
	task automatic report(input string what);
		$display("ERROR at %0t: %s", $time, what);
		errors++;
	endtask

	// advance the predicted bank by one command word and queue its responses
	task automatic apply_timer_cmd(input cmd_t c);
		rsp_t w;
		rsp_t held;
		bit have_held;
		int unsigned id;
		int unsigned pos;
		int n;
		w = '0;
		w.status = ST_OK;
		w.last = 1'b1;
		id = c.timer_id;
		case (c.op)
			OP_SET: begin
				if (id >= N_TIMERS || is_armed[id]) begin
					w.status = ST_INVALID;
				end else begin
					due_at[id] = now_tick + c.timeout_ticks;
					is_armed[id] = 1'b1;
					// behind every queued timer whose deadline is not later
					pos = 0;
					while (pos < deadline_order.size() &&
						due_at[deadline_order[pos]] <= due_at[id])
						pos++;
					deadline_order.insert(pos, id);
				end
				expected_rsp.push_back(w);
			end
			OP_CANCEL: begin
				if (id >= N_TIMERS || !is_armed[id]) begin
					w.status = ST_INVALID;
				end else begin
					is_armed[id] = 1'b0;
					pos = 0;
					while (pos < deadline_order.size() && deadline_order[pos] != id)
						pos++;
					if (pos < deadline_order.size())
						deadline_order.delete(pos);
				end
				expected_rsp.push_back(w);
			end
			OP_TICK: begin
				now_tick = now_tick + 1;
				n = 0;
				have_held = 0;
				// expire due timers from the queue front, at most MAX_RESULTS
				while (n < MAX_RESULTS && deadline_order.size() > 0 &&
					due_at[deadline_order[0]] <= now_tick) begin
					id = deadline_order.pop_front();
					is_armed[id] = 1'b0;
					if (fire_count[id] != '1)
						fire_count[id]++;
					if (have_held)
						expected_rsp.push_back(held);
					held = '0;
					held.status = ST_OK;
					held.expired_valid = 1'b1;
					held.expired_id = id[ID_W-1:0];
					held.expiry_count = fire_count[id];
					held.last = 1'b0;
					have_held = 1;
					n++;
				end
				if (have_held) begin
					held.last = 1'b1;
					expected_rsp.push_back(held);
				end else begin
					expected_rsp.push_back(w);
				end
			end
			default: begin
				w.status = ST_INVALID;
				expected_rsp.push_back(w);
			end
		endcase
	endtask

	// watch both channels at every edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_tick = '0;
			for (int i = 0; i < N_TIMERS; i++) begin
				due_at[i] = '0;
				is_armed[i] = 1'b0;
				fire_count[i] = '0;
			end
			deadline_order.delete();
			expected_rsp.delete();
			errors = 0;
			words_seen = 0;
			expiries_seen = 0;
			pending <= 0;
		end else begin
			// compare a response word with the oldest expectation
			if (done === 1'b1) begin
				words_seen++;
				if (expected_rsp.size() == 0) begin
					report("response word with nothing expected");
				end else begin
					want = expected_rsp.pop_front();
					if (rsp.status !== want.status)
						report($sformatf("status got %b want %b", rsp.status, want.status));
					if (rsp.expired_valid !== want.expired_valid)
						report($sformatf("expired_valid got %b want %b",
							rsp.expired_valid, want.expired_valid));
					if (rsp.expired_id !== want.expired_id)
						report($sformatf("expired_id got %0d want %0d",
							rsp.expired_id, want.expired_id));
					if (rsp.expiry_count !== want.expiry_count)
						report($sformatf("expiry_count got %0d want %0d",
							rsp.expiry_count, want.expiry_count));
					if (rsp.last !== want.last)
						report($sformatf("last got %b want %b", rsp.last, want.last));
					if (want.expired_valid)
						expiries_seen++;
				end
			end
			// predict the responses of an accepted command word
			if (start === 1'b1 && busy === 1'b0)
				apply_timer_cmd(cmd);
			pending <= expected_rsp.size();
		end
	end

endmodule

FILE: test/multi_timer_deadline_queue_test.sv
`timescale 1ns / 100ps
// stimulus and verdict for the sorted timer queue, checking done beside it
module multi_timer_deadline_queue_test;
	import mtdq_pkg::*;

	localparam int N_TIMERS = 16;
	localparam int RANDOM_ROUNDS = 190;
	// slowest tick: 16 expiries, each bumping its counter and walking the queue
	localparam int DRAIN_CYCLES = 400;
	localparam int CYCLE_LIMIT = 500000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	cmd_t cmd = '0;
	logic done;
	rsp_t rsp;

	int errors;
	int pending;
	int words_seen;
	int expiries_seen;
	int cycle_count = 0;
	int sent = 0;
	int gap_ceiling = 0;

	multi_timer_deadline_queue #(.N_TIMERS(N_TIMERS)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.rsp    (rsp)
	);

	multi_timer_deadline_queue_check #(.N_TIMERS(N_TIMERS)) rsp_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.done          (done),
		.rsp           (rsp),
		.errors        (errors),
		.pending       (pending),
		.words_seen    (words_seen),
		.expiries_seen (expiries_seen)
	);

	// 100 MHz clock
	initial begin
		forever #5 clk = ~clk;
	end

	// hard stop on a hung block
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d words outstanding",
				cycle_count, pending);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// present one command word after a random gap and wait for it to be taken
	task automatic send_word(input logic [1:0] op, input int unsigned id,
		input logic [TIMEOUT_W-1:0] timeout);
		cmd_t c;
		int gap;
		c.op = op;
		c.timer_id = id[ID_W-1:0];
		c.timeout_ticks = timeout;
		gap = (gap_ceiling == 0) ? 0 : $urandom_range(0, gap_ceiling);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy !== 1'b0);
		sent++;
	endtask

	// mostly short delays so timers expire, now and then a very long one
	function automatic logic [TIMEOUT_W-1:0] pick_timeout();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return $urandom_range(0, 6);
		if (roll < 92)
			return $urandom_range(7, 60);
		return $urandom;
	endfunction

	initial begin
		int unsigned roll;
		int unsigned delay;

		// hold reset, then release it
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty tick, unused code, cancel of an idle timer
		send_word(OP_TICK, 0, 32'd0);
		send_word(OP_NONE, 15, 32'hFFFF_FFFF);
		send_word(OP_CANCEL, 0, 32'd0);
		// all timers on one deadline, set in reverse id order
		for (int i = 15; i >= 0; i--)
			send_word(OP_SET, i, 32'd0);
		send_word(OP_SET, 15, 32'd5);
		// every timer due on the same tick
		send_word(OP_TICK, 0, 32'd0);
		send_word(OP_SET, 7, 32'd2);
		send_word(OP_CANCEL, 7, 32'd0);
		// longest delay, then a second expiry of a timer already fired once
		send_word(OP_SET, 0, 32'hFFFF_FFFF);
		send_word(OP_SET, 3, 32'd1);
		send_word(OP_TICK, 9, 32'h5A5A_5A5A);

		// random mix with stretches of back-to-back words
		for (int k = 0; k < RANDOM_ROUNDS; k++) begin
			if (k % 24 == 0)
				gap_ceiling = ($urandom_range(0, 2) == 0) ? 0 : 7;
			roll = $urandom_range(0, 99);
			if (roll < 4) begin
				// burst of timers sharing one deadline, then ticks up to it
				delay = $urandom_range(0, 3);
				repeat ($urandom_range(3, 8))
					send_word(OP_SET, $urandom_range(0, 15), delay);
				repeat (delay + 1)
					send_word(OP_TICK, $urandom_range(0, 15), $urandom);
			end else if (roll < 42) begin
				send_word(OP_SET, $urandom_range(0, 15), pick_timeout());
			end else if (roll < 60) begin
				send_word(OP_CANCEL, $urandom_range(0, 15), $urandom);
			end else if (roll < 95) begin
				send_word(OP_TICK, $urandom_range(0, 15), $urandom);
			end else begin
				send_word(OP_NONE, $urandom_range(0, 15), $urandom);
			end
		end
		start <= 1'b0;

		// let every expected word arrive, then watch for strays
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d command words; checked %0d response words, %0d of them expiries",
			sent, words_seen, expiries_seen);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/mtdq_pkg.sv
hw/rtl/mtdq_cnt.sv
hw/rtl/multi_timer_deadline_queue.sv
hw/rtl/mtdq_chk.sv
test/multi_timer_deadline_queue_check.sv
test/multi_timer_deadline_queue_test.sv
